FILE: rtl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// shared constants and types of the work-stealing deque unit
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam int DEPTH_DEFAULT      = 256;
    localparam int ENTRY_BITS_DEFAULT = 32;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int TASK_W   = 32;

    // operation codes
    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TAKE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STEAL = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [0:0]
    {
        S_IDLE = 1'b0,
        S_RESP = 1'b1
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed
    {
        logic start;
    } dp_cmd_t;

endpackage

FILE: rtl/wsd_if.sv
// ----------------------------------------------------------------------------
// wsd request and response channels
// valid/ready channels carrying deque operations and their results
// ----------------------------------------------------------------------------
interface wsd_req_if;
    logic                          valid;
    logic                          ready;
    logic [wsd_pkg::CMD_W-1:0]     cmd;
    logic [wsd_pkg::TASK_W-1:0]    push_value;

    modport source (output valid, output cmd, output push_value, input ready);
    modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface wsd_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [wsd_pkg::TASK_W-1:0]    task_value;
    logic [wsd_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output task_value, output status, input ready);
    modport sink   (input valid, input task_value, input status, output ready);
endinterface

FILE: rtl/wsd_ctrl.sv
// ----------------------------------------------------------------------------
// wsd_ctrl
// handshake controller: starts one operation per transfer and holds the result
// ----------------------------------------------------------------------------
module wsd_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output wsd_pkg::dp_cmd_t  dp_cmd
);

    wsd_pkg::ctrl_state_t state_reg;
    wsd_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wsd_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        dp_cmd.start = 1'b0;
        case (state_reg)
            wsd_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    dp_cmd.start = 1'b1;
                    state_next   = wsd_pkg::S_RESP;
                end
            end
            wsd_pkg::S_RESP:
            begin
                out_valid = 1'b1;
                // a new operation may start in the cycle the result is taken
                in_ready  = out_ready;
                if (out_ready)
                begin
                    if (in_valid)
                    begin
                        dp_cmd.start = 1'b1;
                    end
                    else
                    begin
                        state_next = wsd_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = wsd_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/wsd_datapath.sv
// ----------------------------------------------------------------------------
// wsd_datapath
// task store, top and bottom indices, and the result registers
// ----------------------------------------------------------------------------
module wsd_datapath
#(
    parameter int DEPTH      = wsd_pkg::DEPTH_DEFAULT,
    parameter int ENTRY_BITS = wsd_pkg::ENTRY_BITS_DEFAULT
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  wsd_pkg::dp_cmd_t                dp_cmd,
    input  logic [wsd_pkg::CMD_W-1:0]       cmd,
    input  logic [wsd_pkg::TASK_W-1:0]      push_value,
    output logic [wsd_pkg::TASK_W-1:0]      task_value,
    output logic [wsd_pkg::STATUS_W-1:0]    status
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W  = $clog2(2 * DEPTH);
    localparam logic [IDX_W-1:0] IDX_MAX   = IDX_W'(2 * DEPTH - 1);
    localparam logic [IDX_W-1:0] IDX_DEPTH = IDX_W'(DEPTH);
    localparam logic [IDX_W-1:0] IDX_WRAP  = IDX_W'(2 * DEPTH);
    localparam int STATUS_W_L = wsd_pkg::STATUS_W;

    logic [ENTRY_BITS-1:0] mem [DEPTH];

    logic [IDX_W-1:0]           top_reg, top_next;
    logic [IDX_W-1:0]           bottom_reg, bottom_next;
    logic [STATUS_W_L-1:0]      status_reg, status_next;
    logic                       use_rd_reg, use_rd_next;
    logic [ENTRY_BITS-1:0]      rdata_reg;

    logic [IDX_W:0]             diff;
    logic [IDX_W-1:0]           count;
    logic [IDX_W-1:0]           bottom_dec;
    logic                       wr_en, rd_en;
    logic [ADDR_W-1:0]          wr_addr, rd_addr;
    logic [63:0]                push_wide;
    logic [63:0]                rdata_wide;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] x);
        return (x == IDX_MAX) ? '0 : x + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] x);
        return (x == '0) ? IDX_MAX : x - IDX_W'(1);
    endfunction

    // counter value in [0, 2*DEPTH) folded onto a store slot
    function automatic logic [ADDR_W-1:0] slot_of(input logic [IDX_W-1:0] x);
        logic [IDX_W-1:0] s;
        s = (x >= IDX_DEPTH) ? x - IDX_DEPTH : x;
        return s[ADDR_W-1:0];
    endfunction

    assign diff       = {1'b0, bottom_reg} - {1'b0, top_reg};
    assign count      = diff[IDX_W] ? diff[IDX_W-1:0] + IDX_WRAP : diff[IDX_W-1:0];
    assign bottom_dec = idx_dec(bottom_reg);
    assign push_wide  = 64'(push_value);

    always_comb
    begin
        top_next    = top_reg;
        bottom_next = bottom_reg;
        status_next = status_reg;
        use_rd_next = use_rd_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        wr_addr     = slot_of(bottom_reg);
        rd_addr     = slot_of(top_reg);
        if (dp_cmd.start)
        begin
            status_next = wsd_pkg::ST_OK;
            use_rd_next = 1'b0;
            case (cmd)
                wsd_pkg::CMD_PUSH:
                begin
                    if (count == IDX_DEPTH)
                    begin
                        status_next = wsd_pkg::ST_FULL;
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        bottom_next = idx_inc(bottom_reg);
                    end
                end
                wsd_pkg::CMD_TAKE:
                begin
                    if (count == '0)
                    begin
                        status_next = wsd_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        rd_en       = 1'b1;
                        use_rd_next = 1'b1;
                        rd_addr     = slot_of(bottom_dec);
                        // last entry: top moves, as the cas path would
                        if (count == IDX_W'(1))
                        begin
                            top_next = idx_inc(top_reg);
                        end
                        else
                        begin
                            bottom_next = bottom_dec;
                        end
                    end
                end
                wsd_pkg::CMD_STEAL:
                begin
                    if (count == '0)
                    begin
                        status_next = wsd_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        rd_en       = 1'b1;
                        use_rd_next = 1'b1;
                        top_next    = idx_inc(top_reg);
                    end
                end
                default:
                begin
                    status_next = wsd_pkg::ST_EMPTY;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg    <= '0;
            bottom_reg <= '0;
            status_reg <= wsd_pkg::ST_OK;
            use_rd_reg <= 1'b0;
        end
        else
        begin
            top_reg    <= top_next;
            bottom_reg <= bottom_next;
            status_reg <= status_next;
            use_rd_reg <= use_rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= push_wide[ENTRY_BITS-1:0];
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign rdata_wide = 64'(rdata_reg);
    assign task_value = use_rd_reg ? rdata_wide[wsd_pkg::TASK_W-1:0] : '0;
    assign status     = status_reg;

endmodule

FILE: rtl/work_stealing_deque_unit.sv
// ----------------------------------------------------------------------------
// work_stealing_deque_unit
// chase-lev style task deque on a circular store with push, take and steal
// ----------------------------------------------------------------------------
// Each request transfer carries one operation and yields exactly one response.
// The response is valid in the cycle after the request transfer, because the
// store read data is registered; a new request is taken in the same cycle the
// pending response transfers, so with the response side always ready one
// operation completes per cycle and the first response shows in the cycle after
// its request. The store is a single array written at one address and read at
// one address per cycle; it needs no clearing after reset, since only live
// entries are ever read. A push to a full deque is dropped with status full,
// take or steal on an empty deque answers empty, and unused command code 3
// answers empty with no effect.
module work_stealing_deque_unit
#(
    parameter int DEPTH      = wsd_pkg::DEPTH_DEFAULT,
    parameter int ENTRY_BITS = wsd_pkg::ENTRY_BITS_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    wsd_req_if.sink  req,
    wsd_rsp_if.source rsp
);

    wsd_pkg::dp_cmd_t dp_cmd;

    wsd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .dp_cmd    (dp_cmd)
    );

    wsd_datapath #(
        .DEPTH      (DEPTH),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .dp_cmd     (dp_cmd),
        .cmd        (req.cmd),
        .push_value (req.push_value),
        .task_value (rsp.task_value),
        .status     (rsp.status)
    );

endmodule

FILE: rtl/wsd_checker.sv
// ----------------------------------------------------------------------------
// wsd_checker
// port-level checks of the deque unit, bound to the top level
// ----------------------------------------------------------------------------
module wsd_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic [wsd_pkg::CMD_W-1:0]       cmd,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [wsd_pkg::TASK_W-1:0]      task_value,
    input logic [wsd_pkg::STATUS_W-1:0]    status
);

    logic in_xfer;
    assign in_xfer = in_valid && in_ready;

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(task_value) && $stable(status))
        else $error("response changed while stalled");

    // nothing is returned unless status is ok
    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != wsd_pkg::ST_OK |-> task_value == '0)
        else $error("task value nonzero on failed operation");

    // every request transfer gives a response in the next cycle
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> out_valid)
        else $error("no response after request transfer");

    // a push never answers empty
    a_push_status: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && cmd == wsd_pkg::CMD_PUSH |=> status != wsd_pkg::ST_EMPTY)
        else $error("push answered empty");

    // full only ever answers a push
    a_full_only_push: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && cmd != wsd_pkg::CMD_PUSH |=> status != wsd_pkg::ST_FULL)
        else $error("full status on non-push operation");

endmodule

bind work_stealing_deque_unit wsd_checker u_wsd_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .cmd        (req.cmd),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .task_value (rsp.task_value),
    .status     (rsp.status)
);
